[design/xoro_pkg.sv]
// ----------------------------------------------------------------------------
// xoro_pkg
// Shared constants, control word layout and microcode program of the
// xoroshiro128++ generator unit.
// ----------------------------------------------------------------------------
package xoro_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned HALF_W = 32;
	localparam int unsigned PC_W   = 5;

	// operation codes of an input item
	localparam logic [2:0] OPN_NEXT       = 3'd0;
	localparam logic [2:0] OPN_NEXT_FLOAT = 3'd1;
	localparam logic [2:0] OPN_SEED_RAW   = 3'd2;
	localparam logic [2:0] OPN_SEED_LONG  = 3'd3;
	localparam logic [2:0] OPN_DERIVE_AT  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_MAGIC_LO = 2'd0;
	localparam logic [1:0] CFG_MAGIC_HI = 2'd1;

	localparam logic [WORD_W-1:0] MAGIC_LO_RST = 64'h6a09e667f3bcc909;
	localparam logic [WORD_W-1:0] MAGIC_HI_RST = 64'h9e3779b97f4a7c15;

	localparam logic [WORD_W-1:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] MIX_C2   = 64'h94d049bb133111eb;
	localparam logic [HALF_W-1:0] POS_KX   = 32'd3129871;
	localparam logic [WORD_W-1:0] POS_KZ   = 64'd116129781;
	localparam logic [WORD_W-1:0] POS_KSQ  = 64'd42317861;
	localparam logic [WORD_W-1:0] POS_KLIN = 64'd11;

	// datapath micro-operations
	localparam logic [3:0] UOP_NOP    = 4'd0;
	localparam logic [3:0] UOP_ADV    = 4'd1;
	localparam logic [3:0] UOP_RAW    = 4'd2;
	localparam logic [3:0] UOP_LPRE_A = 4'd3;
	localparam logic [3:0] UOP_MUL_LL = 4'd4;
	localparam logic [3:0] UOP_MUL_LH = 4'd5;
	localparam logic [3:0] UOP_MUL_HL = 4'd6;
	localparam logic [3:0] UOP_MIX2   = 4'd7;
	localparam logic [3:0] UOP_LPRE_B = 4'd8;
	localparam logic [3:0] UOP_LLOAD  = 4'd9;
	localparam logic [3:0] UOP_DPRE   = 4'd10;
	localparam logic [3:0] UOP_DSQ    = 4'd11;
	localparam logic [3:0] UOP_DK     = 4'd12;
	localparam logic [3:0] UOP_DLIN   = 4'd13;
	localparam logic [3:0] UOP_DEMIT  = 4'd14;

	// sequencing of the step counter
	localparam logic [1:0] SEQ_NEXT   = 2'd0;
	localparam logic [1:0] SEQ_END    = 2'd1;
	localparam logic [1:0] SEQ_JUMP   = 2'd2;
	localparam logic [1:0] SEQ_BRANCH = 2'd3;

	// program entry points
	localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
	localparam logic [PC_W-1:0] PC_NEXT  = 5'd1;
	localparam logic [PC_W-1:0] PC_RAW   = 5'd2;
	localparam logic [PC_W-1:0] PC_LONG  = 5'd3;
	localparam logic [PC_W-1:0] PC_LMUL  = 5'd4;
	localparam logic [PC_W-1:0] PC_LLOAD = 5'd13;
	localparam logic [PC_W-1:0] PC_DER   = 5'd14;

	typedef struct packed {
		logic [3:0]      uop;
		logic [1:0]      seq;
		logic            emit;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t cw(logic [3:0] uop, logic [1:0] seq, logic emit,
			logic [PC_W-1:0] target);
		ctrl_word_t w;
		w.uop    = uop;
		w.seq    = seq;
		w.emit   = emit;
		w.target = target;
		return w;
	endfunction

	function automatic ctrl_word_t rom_word(logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			5'd0:  w = cw(UOP_NOP,    SEQ_END,    1'b0, PC_IDLE);
			5'd1:  w = cw(UOP_ADV,    SEQ_END,    1'b1, PC_IDLE);
			5'd2:  w = cw(UOP_RAW,    SEQ_END,    1'b0, PC_IDLE);
			5'd3:  w = cw(UOP_LPRE_A, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd4:  w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd5:  w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd6:  w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd7:  w = cw(UOP_MIX2,   SEQ_NEXT,   1'b0, PC_IDLE);
			5'd8:  w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd9:  w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd10: w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd11: w = cw(UOP_NOP,    SEQ_BRANCH, 1'b0, PC_LLOAD);
			5'd12: w = cw(UOP_LPRE_B, SEQ_JUMP,   1'b0, PC_LMUL);
			5'd13: w = cw(UOP_LLOAD,  SEQ_END,    1'b0, PC_IDLE);
			5'd14: w = cw(UOP_DPRE,   SEQ_NEXT,   1'b0, PC_IDLE);
			5'd15: w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd16: w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd17: w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd18: w = cw(UOP_DSQ,    SEQ_NEXT,   1'b0, PC_IDLE);
			5'd19: w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd20: w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd21: w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd22: w = cw(UOP_DK,     SEQ_NEXT,   1'b0, PC_IDLE);
			5'd23: w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd24: w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd25: w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd26: w = cw(UOP_DLIN,   SEQ_NEXT,   1'b0, PC_IDLE);
			5'd27: w = cw(UOP_MUL_LL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd28: w = cw(UOP_MUL_LH, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd29: w = cw(UOP_MUL_HL, SEQ_NEXT,   1'b0, PC_IDLE);
			5'd30: w = cw(UOP_DEMIT,  SEQ_END,    1'b1, PC_IDLE);
			default: w = cw(UOP_NOP,  SEQ_END,    1'b0, PC_IDLE);
		endcase
		return w;
	endfunction

	function automatic logic [PC_W-1:0] entry_pc(logic [2:0] operation);
		logic [PC_W-1:0] pc;
		case (operation)
			OPN_NEXT:       pc = PC_NEXT;
			OPN_NEXT_FLOAT: pc = PC_NEXT;
			OPN_SEED_RAW:   pc = PC_RAW;
			OPN_SEED_LONG:  pc = PC_LONG;
			OPN_DERIVE_AT:  pc = PC_DER;
			default:        pc = PC_IDLE;
		endcase
		return pc;
	endfunction

endpackage

[design/xoroshiro128pp_generator_unit.sv]
// ----------------------------------------------------------------------------
// xoroshiro128pp_generator_unit
// Xoroshiro128++ generator driven by a microcode sequencer over a datapath
// with one shared 32x32 multiplier for seeding and position derivation.
// ----------------------------------------------------------------------------
// operations: next, next_float and derive_at emit a result; seed_raw and
//   seed_long load the new state
// flow: one item at a time, with a wait on out_ready at the emitting step;
//   64-bit products take three multiplier passes
// reset: magic words and state to reset values, sequencer idle, output empty
module xoroshiro128pp_generator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [63:0]        word_a,
	input  logic [63:0]        word_b,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        value,
	output logic [63:0]        value_hi,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	logic [xoro_pkg::PC_W-1:0]   pc_q;
	logic                        phase_q;
	logic                        out_valid_q;
	logic [2:0]                  op_q;
	logic [63:0]                 a_q, b_q;
	logic [31:0]                 px_q, py_q, pz_q;
	logic [63:0]                 magic_lo_q, magic_hi_q;
	logic [63:0]                 state_lo_q, state_hi_q;
	logic [63:0]                 x_q, y_q, p_q, s_q, w_q;
	logic [63:0]                 value_q, value_hi_q;

	xoro_pkg::ctrl_word_t        cword;
	logic                        run;
	logic                        accept;

	logic [31:0]                 mul_a, mul_b;
	logic [63:0]                 prod;
	logic [63:0]                 adv_sum, adv_res, adv_t, adv_lo, adv_hi;
	logic [63:0]                 fin_p, pre_a, pre_b, seed_a, seed_b, dsq;
	logic [31:0]                 xm;
	logic [63:0]                 dsum, dsar;

	assign cword     = xoro_pkg::rom_word(pc_q);
	assign in_ready  = (pc_q == xoro_pkg::PC_IDLE);
	assign accept    = in_valid && in_ready;
	assign run       = (pc_q != xoro_pkg::PC_IDLE) &&
		!(cword.emit && out_valid_q && !out_ready);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign value_hi  = value_hi_q;

	// shared multiplier, halves picked by the micro-operation
	always_comb begin
		mul_a = (cword.uop == xoro_pkg::UOP_MUL_HL) ? x_q[63:32] : x_q[31:0];
		mul_b = (cword.uop == xoro_pkg::UOP_MUL_LH) ? y_q[63:32] : y_q[31:0];
		prod  = {32'd0, mul_a} * {32'd0, mul_b};
	end

	always_comb begin
		adv_sum = state_lo_q + state_hi_q;
		adv_res = {adv_sum[46:0], adv_sum[63:47]} + state_lo_q;
		adv_t   = state_hi_q ^ state_lo_q;
		adv_lo  = {state_lo_q[14:0], state_lo_q[63:15]} ^ adv_t ^ {adv_t[42:0], 21'd0};
		adv_hi  = {adv_t[35:0], adv_t[63:36]};
		fin_p   = p_q ^ {31'd0, p_q[63:31]};
		seed_a  = a_q ^ magic_lo_q;
		pre_a   = seed_a ^ {30'd0, seed_a[63:30]};
		seed_b  = s_q + magic_hi_q;
		pre_b   = seed_b ^ {30'd0, seed_b[63:30]};
		xm      = px_q * xoro_pkg::POS_KX;
		dsq     = s_q ^ p_q;
		dsum    = w_q + p_q;
		dsar    = {{16{dsum[63]}}, dsum[63:16]};
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= xoro_pkg::PC_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (run && cword.emit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				pc_q    <= xoro_pkg::entry_pc(operation);
				phase_q <= 1'b0;
			end else if (run) begin
				if (cword.uop == xoro_pkg::UOP_LPRE_B)
					phase_q <= 1'b1;
				case (cword.seq)
					xoro_pkg::SEQ_NEXT:   pc_q <= pc_q + 5'd1;
					xoro_pkg::SEQ_END:    pc_q <= xoro_pkg::PC_IDLE;
					xoro_pkg::SEQ_JUMP:   pc_q <= cword.target;
					xoro_pkg::SEQ_BRANCH: pc_q <= phase_q ? cword.target : pc_q + 5'd1;
					default:              pc_q <= xoro_pkg::PC_IDLE;
				endcase
			end
		end
	end

	// magic words and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_lo_q <= xoro_pkg::MAGIC_LO_RST;
			magic_hi_q <= xoro_pkg::MAGIC_HI_RST;
			state_lo_q <= xoro_pkg::MAGIC_HI_RST;
			state_hi_q <= xoro_pkg::MAGIC_LO_RST;
		end else begin
			if (cfg_valid && cfg_index == xoro_pkg::CFG_MAGIC_LO)
				magic_lo_q <= cfg_data;
			if (cfg_valid && cfg_index == xoro_pkg::CFG_MAGIC_HI)
				magic_hi_q <= cfg_data;
			if (run) begin
				case (cword.uop)
					xoro_pkg::UOP_ADV: begin
						state_lo_q <= adv_lo;
						state_hi_q <= adv_hi;
					end
					xoro_pkg::UOP_RAW: begin
						if (a_q == 64'd0 && b_q == 64'd0) begin
							state_lo_q <= magic_hi_q;
							state_hi_q <= magic_lo_q;
						end else begin
							state_lo_q <= a_q;
							state_hi_q <= b_q;
						end
					end
					xoro_pkg::UOP_LLOAD: begin
						if (w_q == 64'd0 && fin_p == 64'd0) begin
							state_lo_q <= magic_hi_q;
							state_hi_q <= magic_lo_q;
						end else begin
							state_lo_q <= w_q;
							state_hi_q <= fin_p;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// captured item and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			a_q  <= word_a;
			b_q  <= word_b;
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
		end
		if (run) begin
			case (cword.uop)
				xoro_pkg::UOP_ADV: begin
					value_q    <= (op_q == xoro_pkg::OPN_NEXT_FLOAT) ?
						{40'd0, adv_res[63:40]} : adv_res;
					value_hi_q <= 64'd0;
				end
				xoro_pkg::UOP_LPRE_A: begin
					s_q <= seed_a;
					x_q <= pre_a;
					y_q <= xoro_pkg::MIX_C1;
				end
				xoro_pkg::UOP_MUL_LL: p_q <= prod;
				xoro_pkg::UOP_MUL_LH: p_q <= p_q + {prod[31:0], 32'd0};
				xoro_pkg::UOP_MUL_HL: p_q <= p_q + {prod[31:0], 32'd0};
				xoro_pkg::UOP_MIX2: begin
					x_q <= p_q ^ {27'd0, p_q[63:27]};
					y_q <= xoro_pkg::MIX_C2;
				end
				xoro_pkg::UOP_LPRE_B: begin
					w_q <= fin_p;
					x_q <= pre_b;
					y_q <= xoro_pkg::MIX_C1;
				end
				xoro_pkg::UOP_DPRE: begin
					s_q <= {{32{xm[31]}}, xm} ^ {{32{py_q[31]}}, py_q};
					x_q <= {{32{pz_q[31]}}, pz_q};
					y_q <= xoro_pkg::POS_KZ;
				end
				xoro_pkg::UOP_DSQ: begin
					s_q <= dsq;
					x_q <= dsq;
					y_q <= dsq;
				end
				xoro_pkg::UOP_DK: begin
					x_q <= p_q;
					y_q <= xoro_pkg::POS_KSQ;
				end
				xoro_pkg::UOP_DLIN: begin
					w_q <= p_q;
					x_q <= s_q;
					y_q <= xoro_pkg::POS_KLIN;
				end
				xoro_pkg::UOP_DEMIT: begin
					value_q    <= dsar ^ state_lo_q;
					value_hi_q <= state_hi_q;
				end
				default: begin
				end
			endcase
		end
	end

	a_emit_from_rom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cword.emit))
		else $error("result raised without an emitting step");

	a_phase_in_long: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (op_q == xoro_pkg::OPN_SEED_LONG))
		else $error("second mix pass outside long seeding");

	a_next_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == xoro_pkg::OPN_NEXT) |=> (!in_ready && cword.emit))
		else $error("next did not dispatch to the advance step");

endmodule
